[sv/hall_sector_lap_counter_macros.svh]
// Assertion macros for the hall sector and lap counter.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef HALL_SECTOR_LAP_COUNTER_MACROS_SVH
`define HALL_SECTOR_LAP_COUNTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define HSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define HSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/hsl_pkg.sv]
// Package for the hall sector and lap counter: sizes, codes and the word types
// passed between the front and back parts. No dependencies.
package hsl_pkg;

    // sizing
    localparam int SENSORS       = 2;
    localparam int HISTORY_DEPTH = 8;
    localparam int SENS_W        = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
    localparam int SUM_W         = $clog2(HISTORY_DEPTH + 16) + 1;

    // field widths
    localparam int OP_W       = 2;
    localparam int SENSOR_W   = 1;
    localparam int STAMP_W    = 32;
    localparam int BACK_W     = 4;
    localparam int SECTOR_W   = 10;
    localparam int LAP_W      = 32;
    localparam int TICKS_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int CD_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [SECTOR_W-1:0] SPL_RESET  = 10'd12;
    localparam logic [CD_W-1:0]     WLEN_RESET = 16'd100;

    // saturation limits of the window count
    localparam logic signed [TICKS_W-1:0] TICK_MAX = 8'sd127;
    localparam logic signed [TICKS_W-1:0] TICK_MIN = -8'sd128;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_EDGE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_QUERY = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // status codes
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_OK           = 2'd0;
    localparam t_status ST_HIST_RANGE   = 2'd1;
    localparam t_status ST_SECTOR_RANGE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_DOWN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPL        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WLEN       = 2'd2;

    // classified command word, front to back
    typedef struct packed {
        t_op                 op;
        logic                sensor_ok;
        logic [SENS_W-1:0]   sidx;
        logic [STAMP_W-1:0]  stamp;
        logic [BACK_W-1:0]   back;
        logic                back_bad;
    } t_cmd;

    // result word
    typedef struct packed {
        logic [SECTOR_W-1:0]       sector;
        logic signed [LAP_W-1:0]   lap;
        logic signed [TICKS_W-1:0] ticks;
        logic [STAMP_W-1:0]        htime;
        t_status                   status;
    } t_res;

endpackage

[sv/hsl_front.sv]
// Front part: accepts input words, classifies them into command words and
// holds them in a two-entry command queue. Depends on hsl_pkg.
module hsl_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [hsl_pkg::OP_W-1:0]      i_opcode,
    input  logic [hsl_pkg::SENSOR_W-1:0]  i_sensor,
    input  logic [hsl_pkg::STAMP_W-1:0]   i_timestamp_ms,
    input  logic [hsl_pkg::BACK_W-1:0]    i_history_back,
    output logic                          o_cmd_valid,
    input  logic                          i_cmd_pop,
    output hsl_pkg::t_cmd                 o_cmd
);

    hsl_pkg::t_cmd w_cmd;
    hsl_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    logic          w_push;

    // classify the incoming word
    always_comb begin
        w_cmd.op        = hsl_pkg::t_op'(i_opcode);
        w_cmd.sensor_ok = (32'(i_sensor) < 32'(hsl_pkg::SENSORS));
        w_cmd.sidx      = hsl_pkg::SENS_W'(i_sensor);
        w_cmd.stamp     = i_timestamp_ms;
        w_cmd.back      = i_history_back;
        w_cmd.back_bad  = (32'(i_history_back) > 32'(hsl_pkg::HISTORY_DEPTH));
    end

    assign full        = (r_cnt == 2'd2);
    assign w_push      = push && !full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // occupancy
    always_comb begin
        case ({w_push, i_cmd_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

[sv/hsl_back.sv]
// Back part: holds the registers and per-sensor state, carries out one command
// word a cycle unless its two-entry result queue is full. Depends on hsl_pkg.
module hsl_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hsl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hsl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_cmd_valid,
    input  hsl_pkg::t_cmd                   i_cmd,
    output logic                            o_cmd_pop,
    output logic                            empty,
    input  logic                            pop,
    output hsl_pkg::t_res                   o_res
);

    localparam int S       = hsl_pkg::SENSORS;
    localparam int D       = hsl_pkg::HISTORY_DEPTH;
    localparam int SUM_W_L = hsl_pkg::SUM_W;

    // registers
    logic                          r_count_down;
    logic [hsl_pkg::SECTOR_W-1:0]  r_spl;
    logic [hsl_pkg::CD_W-1:0]      r_wlen;

    // per-sensor state
    logic [hsl_pkg::SLOT_W-1:0]          r_ws  [S];
    logic [hsl_pkg::SECTOR_W-1:0]        r_sec [S];
    logic [hsl_pkg::LAP_W-1:0]           r_lap [S];
    logic signed [hsl_pkg::TICKS_W-1:0]  r_run [S];
    logic signed [hsl_pkg::TICKS_W-1:0]  r_lat [S];
    logic [hsl_pkg::SLOT_W-1:0]          n_ws  [S];
    logic [hsl_pkg::SECTOR_W-1:0]        n_sec [S];
    logic [hsl_pkg::LAP_W-1:0]           n_lap [S];
    logic signed [hsl_pkg::TICKS_W-1:0]  n_run [S];
    logic signed [hsl_pkg::TICKS_W-1:0]  n_lat [S];
    logic [hsl_pkg::CD_W-1:0]            r_cd;
    logic [hsl_pkg::CD_W-1:0]            n_cd;

    // edge history: data without reset, valid bits cleared on reset and clear
    logic [hsl_pkg::STAMP_W-1:0]  r_hist [S][D];
    logic [D-1:0]                 r_hvld [S];
    logic                         w_hist_we;
    logic                         w_hist_clr;

    // result queue
    hsl_pkg::t_res  r_rq [2];
    logic           r_rwp;
    logic           r_rrp;
    logic [1:0]     r_rcnt;
    logic [1:0]     n_rcnt;
    logic           w_go;
    logic           w_rpop;
    hsl_pkg::t_res  w_res;

    logic [hsl_pkg::SECTOR_W-1:0]  w_lap_n;
    logic [hsl_pkg::SENS_W-1:0]    w_s;

    assign w_lap_n   = (r_spl == '0) ? hsl_pkg::SECTOR_W'(1) : r_spl;
    assign w_s       = i_cmd.sidx;
    assign w_go      = i_cmd_valid && (r_rcnt != 2'd2);
    assign o_cmd_pop = w_go;
    assign w_rpop    = pop && !empty;
    assign empty     = (r_rcnt == 2'd0);
    assign o_res     = r_rq[r_rrp];

    // execute: next state of the per-sensor counters and window
    always_comb begin
        logic [hsl_pkg::SECTOR_W:0]    sec_p1;
        logic [hsl_pkg::SECTOR_W-1:0]  sec_m1;
        logic [hsl_pkg::CD_W-1:0]      cd_m1;
        sec_p1 = {1'b0, r_sec[w_s]} + (hsl_pkg::SECTOR_W + 1)'(1);
        sec_m1 = r_sec[w_s] - hsl_pkg::SECTOR_W'(1);
        cd_m1  = r_cd - hsl_pkg::CD_W'(1);
        for (int i = 0; i < S; i++) begin
            n_ws[i]  = r_ws[i];
            n_sec[i] = r_sec[i];
            n_lap[i] = r_lap[i];
            n_run[i] = r_run[i];
            n_lat[i] = r_lat[i];
        end
        n_cd       = r_cd;
        w_hist_we  = 1'b0;
        w_hist_clr = 1'b0;
        case (i_cmd.op)
            hsl_pkg::OP_EDGE: begin
                if (i_cmd.sensor_ok) begin
                    w_hist_we = 1'b1;
                    n_ws[w_s] = (r_ws[w_s] == hsl_pkg::SLOT_W'(D - 1)) ? '0
                              : r_ws[w_s] + hsl_pkg::SLOT_W'(1);
                    if (r_count_down) begin
                        if (r_sec[w_s] == '0) begin
                            n_sec[w_s] = w_lap_n - hsl_pkg::SECTOR_W'(1);
                            n_lap[w_s] = r_lap[w_s] - hsl_pkg::LAP_W'(1);
                        end else if (sec_m1 >= w_lap_n) begin
                            n_sec[w_s] = '0;
                            n_lap[w_s] = r_lap[w_s] + hsl_pkg::LAP_W'(1);
                        end else begin
                            n_sec[w_s] = sec_m1;
                        end
                        if (r_run[w_s] != hsl_pkg::TICK_MIN) begin
                            n_run[w_s] = r_run[w_s] - hsl_pkg::TICKS_W'(1);
                        end
                    end else begin
                        if (sec_p1 >= {1'b0, w_lap_n}) begin
                            n_sec[w_s] = '0;
                            n_lap[w_s] = r_lap[w_s] + hsl_pkg::LAP_W'(1);
                        end else begin
                            n_sec[w_s] = sec_p1[hsl_pkg::SECTOR_W-1:0];
                        end
                        if (r_run[w_s] != hsl_pkg::TICK_MAX) begin
                            n_run[w_s] = r_run[w_s] + hsl_pkg::TICKS_W'(1);
                        end
                    end
                end
            end
            hsl_pkg::OP_TICK: begin
                if (cd_m1 == '0) begin
                    for (int i = 0; i < S; i++) begin
                        n_lat[i] = r_run[i];
                        n_run[i] = '0;
                    end
                    n_cd = r_wlen;
                end else begin
                    n_cd = cd_m1;
                end
            end
            hsl_pkg::OP_CLEAR: begin
                if (i_cmd.sensor_ok) begin
                    w_hist_clr = 1'b1;
                    n_ws[w_s]  = '0;
                    n_sec[w_s] = '0;
                    n_lap[w_s] = '0;
                    n_run[w_s] = '0;
                    n_lat[w_s] = '0;
                    n_cd       = r_wlen;
                end
            end
            default: begin
            end
        endcase
    end

    // result word for the addressed sensor after the update
    always_comb begin
        logic [SUM_W_L-1:0]           slot_sum;
        logic [SUM_W_L-1:0]           slot_mod;
        logic [hsl_pkg::SLOT_W-1:0]   slot;
        logic                         sec_bad;
        slot_sum = SUM_W_L'(r_ws[w_s]) + SUM_W_L'(D) - SUM_W_L'(i_cmd.back);
        slot_mod = (slot_sum >= SUM_W_L'(D)) ? slot_sum - SUM_W_L'(D) : slot_sum;
        slot     = slot_mod[hsl_pkg::SLOT_W-1:0];
        sec_bad  = (n_sec[w_s] >= w_lap_n);
        w_res    = '0;
        if (i_cmd.sensor_ok) begin
            w_res.sector = sec_bad ? '0 : n_sec[w_s];
            w_res.lap    = $signed(n_lap[w_s]);
            w_res.ticks  = n_lat[w_s];
            if ((i_cmd.op == hsl_pkg::OP_QUERY) && !i_cmd.back_bad && r_hvld[w_s][slot]) begin
                w_res.htime = r_hist[w_s][slot];
            end
            if ((i_cmd.op == hsl_pkg::OP_QUERY) && i_cmd.back_bad) begin
                w_res.status = hsl_pkg::ST_HIST_RANGE;
            end else if (sec_bad) begin
                w_res.status = hsl_pkg::ST_SECTOR_RANGE;
            end else begin
                w_res.status = hsl_pkg::ST_OK;
            end
        end
    end

    // registers and per-sensor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_down <= 1'b0;
            r_spl        <= hsl_pkg::SPL_RESET;
            r_wlen       <= hsl_pkg::WLEN_RESET;
            r_cd         <= hsl_pkg::WLEN_RESET;
            for (int i = 0; i < S; i++) begin
                r_ws[i]   <= '0;
                r_sec[i]  <= '0;
                r_lap[i]  <= '0;
                r_run[i]  <= '0;
                r_lat[i]  <= '0;
                r_hvld[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hsl_pkg::CFG_COUNT_DOWN: r_count_down <= i_cfg_data[0];
                    hsl_pkg::CFG_SPL:        r_spl  <= i_cfg_data[hsl_pkg::SECTOR_W-1:0];
                    hsl_pkg::CFG_WLEN:       r_wlen <= i_cfg_data[hsl_pkg::CD_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_go) begin
                for (int i = 0; i < S; i++) begin
                    r_ws[i]  <= n_ws[i];
                    r_sec[i] <= n_sec[i];
                    r_lap[i] <= n_lap[i];
                    r_run[i] <= n_run[i];
                    r_lat[i] <= n_lat[i];
                end
                r_cd <= n_cd;
                if (w_hist_we) begin
                    r_hvld[w_s][r_ws[w_s]] <= 1'b1;
                end
                if (w_hist_clr) begin
                    r_hvld[w_s] <= '0;
                end
            end
        end
    end

    // history data
    always_ff @(posedge i_clk) begin
        if (w_go && w_hist_we) begin
            r_hist[w_s][r_ws[w_s]] <= i_cmd.stamp;
        end
    end

    // result queue occupancy
    always_comb begin
        case ({w_go, w_rpop})
            2'b10:   n_rcnt = r_rcnt + 2'd1;
            2'b01:   n_rcnt = r_rcnt - 2'd1;
            default: n_rcnt = r_rcnt;
        endcase
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rwp  <= 1'b0;
            r_rrp  <= 1'b0;
            r_rcnt <= 2'd0;
        end else begin
            if (w_go) begin
                r_rwp <= ~r_rwp;
            end
            if (w_rpop) begin
                r_rrp <= ~r_rrp;
            end
            r_rcnt <= n_rcnt;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_rq[r_rwp] <= w_res;
        end
    end

endmodule

[sv/hall_sector_lap_counter.sv]
// Hall sector and lap counter for hsl_pkg::SENSORS sensors. A word pushed on
// the input side is classified and queued in the front part, then carried out
// by the back part, one word per cycle sustained while the result side pops;
// its result word passes the command queue register, then the result queue
// register. Both queues hold two words so that each side may stall on its own.
// Every word gives one result word. Registers must be written through i_cfg_we /
// i_cfg_index / i_cfg_data only while the block is idle (not enforced here).
// Depends on hsl_pkg, hsl_front, hsl_back and hall_sector_lap_counter_macros.svh.
`include "hall_sector_lap_counter_macros.svh"

module hall_sector_lap_counter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hsl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hsl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [hsl_pkg::OP_W-1:0]            i_opcode,
    input  logic [hsl_pkg::SENSOR_W-1:0]        i_sensor,
    input  logic [hsl_pkg::STAMP_W-1:0]         i_timestamp_ms,
    input  logic [hsl_pkg::BACK_W-1:0]          i_history_back,
    output logic                                empty,
    input  logic                                pop,
    output logic [hsl_pkg::SECTOR_W-1:0]        o_sector,
    output logic signed [hsl_pkg::LAP_W-1:0]    o_lap,
    output logic signed [hsl_pkg::TICKS_W-1:0]  o_window_ticks,
    output logic [hsl_pkg::STAMP_W-1:0]         o_history_time,
    output logic [hsl_pkg::STATUS_W-1:0]        o_status
);

    logic           w_cmd_valid;
    logic           w_cmd_pop;
    hsl_pkg::t_cmd  w_cmd;
    hsl_pkg::t_res  w_res;

    // front: accept and classify
    hsl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_sensor       (i_sensor),
        .i_timestamp_ms (i_timestamp_ms),
        .i_history_back (i_history_back),
        .o_cmd_valid    (w_cmd_valid),
        .i_cmd_pop      (w_cmd_pop),
        .o_cmd          (w_cmd)
    );

    // back: execute and queue results
    hsl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_res       (w_res)
    );

    assign o_sector       = w_res.sector;
    assign o_lap          = w_res.lap;
    assign o_window_ticks = w_res.ticks;
    assign o_history_time = w_res.htime;
    assign o_status       = w_res.status;

    // checks
    `HSL_ASSERT_NEXT(a_cmd_arrives, (push && !full && !w_cmd_valid), w_cmd_valid, "pushed word lost before the back part")
    `HSL_ASSERT_NEXT(a_cmd_kept, (w_cmd_valid && !w_cmd_pop), w_cmd_valid, "queued command vanished")
    `HSL_ASSERT_NOW(a_hist_zero, (!empty && o_status == hsl_pkg::ST_HIST_RANGE), (o_history_time == '0), "history time set on a bad query")
    `HSL_ASSERT_NOW(a_sector_zero, (!empty && o_status == hsl_pkg::ST_SECTOR_RANGE), (o_sector == '0), "sector set while out of range")

endmodule

[sim/hsl_lap_checker.sv]
`timescale 1ns / 100ps
// Checker for the hall sector and lap counter: mirrors sector, lap, window and
// edge history state, predicts one result word per accepted word and compares.
// Depends on hsl_pkg only.
module hsl_lap_checker
    import hsl_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_push,
    input  logic                        i_full,
    input  logic [OP_W-1:0]             i_opcode,
    input  logic [SENSOR_W-1:0]         i_sensor,
    input  logic [STAMP_W-1:0]          i_timestamp_ms,
    input  logic [BACK_W-1:0]           i_history_back,
    input  logic                        i_empty,
    input  logic                        i_pop,
    input  logic [SECTOR_W-1:0]         i_sector,
    input  logic signed [LAP_W-1:0]     i_lap,
    input  logic signed [TICKS_W-1:0]   i_window_ticks,
    input  logic [STAMP_W-1:0]          i_history_time,
    input  logic [STATUS_W-1:0]         i_status,
    output int                          o_mismatches,
    output int                          o_pending
);

    // register copies
    logic                      down_mode;
    logic [SECTOR_W-1:0]       lap_sectors;
    logic [CD_W-1:0]           window_len;

    // per-sensor counters and edge history
    logic [SLOT_W-1:0]         next_slot  [SENSORS];
    logic [STAMP_W-1:0]        stamp_ring [SENSORS][HISTORY_DEPTH];
    logic [SECTOR_W-1:0]       sector_pos [SENSORS];
    logic signed [LAP_W-1:0]   lap_total  [SENSORS];
    logic signed [TICKS_W-1:0] ticks_open [SENSORS];
    logic signed [TICKS_W-1:0] ticks_held [SENSORS];
    logic [CD_W-1:0]           window_left;

    t_res awaited_q [$];
    int   mismatch_count = 0;
    int   pending_words  = 0;
    int   words_out      = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_words;

    // a lap of zero sectors behaves as a lap of one
    function automatic int lap_span();
        return (lap_sectors == '0) ? 1 : int'(lap_sectors);
    endfunction

    function automatic void clear_one(int s);
        next_slot[s]  = '0;
        sector_pos[s] = '0;
        lap_total[s]  = '0;
        ticks_open[s] = '0;
        ticks_held[s] = '0;
        for (int k = 0; k < HISTORY_DEPTH; k++)
            stamp_ring[s][k] = '0;
        window_left = window_len;
    endfunction

    function automatic void reset_counters();
        down_mode   = 1'b0;
        lap_sectors = SPL_RESET;
        window_len  = WLEN_RESET;
        for (int s = 0; s < SENSORS; s++)
            clear_one(s);
        window_left = window_len;
    endfunction

    // edge: log the stamp, step the sector with lap carry, step the window count
    function automatic void step_edge(int s, logic [STAMP_W-1:0] stamp);
        int n;
        int pos;
        n   = lap_span();
        pos = int'(sector_pos[s]);
        stamp_ring[s][next_slot[s]] = stamp;
        next_slot[s] = next_slot[s] + 1'b1;
        if (down_mode) begin
            if (pos == 0) begin
                pos = n - 1;
                lap_total[s] = lap_total[s] - 32'sd1;
            end else begin
                pos = pos - 1;
                // stepping down from beyond the lap still wraps forwards
                if (pos >= n) begin
                    pos = 0;
                    lap_total[s] = lap_total[s] + 32'sd1;
                end
            end
            if (ticks_open[s] != TICK_MIN)
                ticks_open[s] = ticks_open[s] - 8'sd1;
        end else begin
            pos = pos + 1;
            if (pos >= n) begin
                pos = 0;
                lap_total[s] = lap_total[s] + 32'sd1;
            end
            if (ticks_open[s] != TICK_MAX)
                ticks_open[s] = ticks_open[s] + 8'sd1;
        end
        sector_pos[s] = SECTOR_W'(pos);
    endfunction

    // time tick: a zero countdown wraps to all ones, reaching zero latches
    function automatic void step_tick();
        window_left = window_left - 1'b1;
        if (window_left == '0) begin
            for (int s = 0; s < SENSORS; s++) begin
                ticks_held[s] = ticks_open[s];
                ticks_open[s] = '0;
            end
            window_left = window_len;
        end
    endfunction

    function automatic t_res predict_word(t_op op, int s, logic [STAMP_W-1:0] stamp,
                                          logic [BACK_W-1:0] back);
        t_res r;
        r = '0;
        case (op)
            OP_EDGE:  step_edge(s, stamp);
            OP_TICK:  step_tick();
            OP_CLEAR: clear_one(s);
            default: ;
        endcase
        if (op == OP_QUERY) begin
            if (int'(back) > HISTORY_DEPTH)
                r.status = ST_HIST_RANGE;
            else
                r.htime = stamp_ring[s][(int'(next_slot[s]) + HISTORY_DEPTH - int'(back))
                                        % HISTORY_DEPTH];
        end
        // sector left beyond a shortened lap reads as zero
        if (int'(sector_pos[s]) >= lap_span()) begin
            if (r.status == ST_OK)
                r.status = ST_SECTOR_RANGE;
        end else begin
            r.sector = sector_pos[s];
        end
        r.lap   = lap_total[s];
        r.ticks = ticks_held[s];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: result word %0d: %s", $time, words_out, what);
        mismatch_count++;
    endtask

    // both channels sampled at the edge, before the bench's drives land
    always @(posedge i_clk) begin : watch_words
        t_res want;
        if (!i_rst_n) begin
            reset_counters();
            awaited_q.delete();
            pending_words <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_COUNT_DOWN: down_mode   = i_cfg_data[0];
                    CFG_SPL:        lap_sectors = i_cfg_data[SECTOR_W-1:0];
                    CFG_WLEN:       window_len  = i_cfg_data[CD_W-1:0];
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                if (awaited_q.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = awaited_q.pop_front();
                    if (i_sector !== want.sector)
                        report_mismatch($sformatf("sector %0d, expected %0d",
                                                  i_sector, want.sector));
                    if (i_lap !== want.lap)
                        report_mismatch($sformatf("lap %0d, expected %0d", i_lap, want.lap));
                    if (i_window_ticks !== want.ticks)
                        report_mismatch($sformatf("window ticks %0d, expected %0d",
                                                  i_window_ticks, want.ticks));
                    if (i_history_time !== want.htime)
                        report_mismatch($sformatf("history time %h, expected %h",
                                                  i_history_time, want.htime));
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, want.status));
                end
                words_out++;
            end
            if (i_push && !i_full)
                awaited_q.push_back(predict_word(t_op'(i_opcode), int'(i_sensor),
                                                 i_timestamp_ms, i_history_back));
            pending_words <= awaited_q.size();
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the hall sector and lap counter: clock, reset, register
// writes and word stimulus; checking is done by hsl_lap_checker.
// Depends on hsl_pkg, hall_sector_lap_counter and hsl_lap_checker.
module tb;
    import hsl_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data     = '0;
    logic                       push           = 1'b0;
    logic                       full;
    logic [OP_W-1:0]            i_opcode       = '0;
    logic [SENSOR_W-1:0]        i_sensor       = '0;
    logic [STAMP_W-1:0]         i_timestamp_ms = '0;
    logic [BACK_W-1:0]          i_history_back = '0;
    logic                       empty;
    logic                       pop            = 1'b0;
    logic [SECTOR_W-1:0]        o_sector;
    logic signed [LAP_W-1:0]    o_lap;
    logic signed [TICKS_W-1:0]  o_window_ticks;
    logic [STAMP_W-1:0]         o_history_time;
    logic [STATUS_W-1:0]        o_status;

    int   mismatches;
    int   pending;
    int   quiet_cycles = 0;
    logic no_gaps      = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    hall_sector_lap_counter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_sensor       (i_sensor),
        .i_timestamp_ms (i_timestamp_ms),
        .i_history_back (i_history_back),
        .empty          (empty),
        .pop            (pop),
        .o_sector       (o_sector),
        .o_lap          (o_lap),
        .o_window_ticks (o_window_ticks),
        .o_history_time (o_history_time),
        .o_status       (o_status)
    );

    hsl_lap_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_push         (push),
        .i_full         (full),
        .i_opcode       (i_opcode),
        .i_sensor       (i_sensor),
        .i_timestamp_ms (i_timestamp_ms),
        .i_history_back (i_history_back),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_sector       (o_sector),
        .i_lap          (o_lap),
        .i_window_ticks (o_window_ticks),
        .i_history_time (o_history_time),
        .i_status       (o_status),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    // result side: pop drawn at random with 76 percent odds, always high during the steady stretch
    always @(posedge i_clk) begin
        pop <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 24);
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one word in, with random gaps ahead of it; returns on the accepting edge
    task automatic send_word(t_op op, logic sel, logic [STAMP_W-1:0] stamp,
                             logic [BACK_W-1:0] back);
        while (!no_gaps && $urandom_range(0, 99) < 24) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_opcode       <= op;
        i_sensor       <= sel;
        i_timestamp_ms <= stamp;
        i_history_back <= back;
        do @(posedge i_clk); while (full);
    endtask

    task automatic send_random(int edge_pct, int tick_pct, int query_pct, int s0_pct);
        int   pick;
        t_op  op;
        pick = $urandom_range(0, 99);
        if (pick < edge_pct)
            op = OP_EDGE;
        else if (pick < edge_pct + tick_pct)
            op = OP_TICK;
        else if (pick < edge_pct + tick_pct + query_pct)
            op = OP_QUERY;
        else
            op = OP_CLEAR;
        send_word(op, ($urandom_range(0, 99) < s0_pct) ? 1'b0 : 1'b1, $urandom,
                  BACK_W'($urandom_range(0, 15)));
    endtask

    // push low, then wait for every expected result word to be popped
    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_config(logic cd, logic [SECTOR_W-1:0] spl, logic [CD_W-1:0] wlen);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_COUNT_DOWN;
        i_cfg_data  <= CFG_DATA_W'(cd);
        @(posedge i_clk);
        i_cfg_index <= CFG_SPL;
        i_cfg_data  <= CFG_DATA_W'(spl);
        @(posedge i_clk);
        i_cfg_index <= CFG_WLEN;
        i_cfg_data  <= CFG_DATA_W'(wlen);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        bit                  burst;
        int                  pick;
        logic [SECTOR_W-1:0] spl;
        logic [CD_W-1:0]     wlen;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: history ends, range errors, tick and clear at reset settings
        set_config(1'b0, SPL_RESET, WLEN_RESET);
        send_word(OP_QUERY, 1'b0, 32'h0000_0000, 4'd0);
        send_word(OP_EDGE,  1'b0, 32'h0000_0000, 4'd15);
        send_word(OP_EDGE,  1'b0, 32'hFFFF_FFFF, 4'd0);
        send_word(OP_EDGE,  1'b1, 32'h5555_AAAA, 4'd0);
        send_word(OP_QUERY, 1'b0, 32'hFFFF_FFFF, 4'd1);
        send_word(OP_QUERY, 1'b0, 32'h0000_0000, 4'd2);
        send_word(OP_QUERY, 1'b0, 32'h0000_0000, 4'd8);
        send_word(OP_QUERY, 1'b0, 32'h0000_0000, 4'd9);
        send_word(OP_QUERY, 1'b1, 32'hAAAA_5555, 4'd15);
        send_word(OP_TICK,  1'b0, 32'h0000_0000, 4'd0);
        send_word(OP_CLEAR, 1'b1, 32'h0000_0000, 4'd0);
        send_word(OP_QUERY, 1'b1, 32'h0000_0000, 4'd0);
        wait_drained();

        // one-sector lap counting down, window of one tick
        set_config(1'b1, 10'd1, 16'd1);
        send_word(OP_CLEAR, 1'b0, 32'h0000_0000, 4'd0);
        send_word(OP_EDGE,  1'b0, 32'h1234_5678, 4'd0);
        send_word(OP_EDGE,  1'b1, 32'h8765_4321, 4'd0);
        send_word(OP_TICK,  1'b1, 32'h0000_0000, 4'd0);
        send_word(OP_QUERY, 1'b0, 32'h0000_0000, 4'd1);
        wait_drained();

        // widest lap, zero window length wraps the countdown
        set_config(1'b0, 10'd1023, 16'd0);
        send_word(OP_CLEAR, 1'b0, 32'h0000_0000, 4'd0);
        send_word(OP_TICK,  1'b0, 32'h0000_0000, 4'd0);
        repeat (4) send_word(OP_EDGE, 1'b0, $urandom, 4'd0);
        wait_drained();

        // zero sectors per lap with the sector left beyond it
        set_config(1'b1, 10'd0, 16'd2);
        send_word(OP_QUERY, 1'b0, 32'h0000_0000, 4'd3);
        send_word(OP_QUERY, 1'b0, 32'h0000_0000, 4'd12);
        send_word(OP_EDGE,  1'b0, 32'hDEAD_0001, 4'd0);
        wait_drained();

        // random phases; bursts pile edges on one sensor to saturate the window count
        for (int ph = 0; ph < 9; ph++) begin
            burst = (ph == 2) || (ph == 5);
            if (ph == 0) begin
                set_config(1'b0, 10'd1023, 16'hFFFF);
            end else if (ph == 1) begin
                set_config(1'b1, 10'd1, 16'd1);
            end else if (burst) begin
                set_config(ph == 5, SECTOR_W'($urandom_range(1, 16)),
                           CD_W'($urandom_range(5, 8)));
            end else begin
                pick = $urandom_range(0, 9);
                spl  = (pick == 0) ? 10'd1023 : (pick == 1) ? 10'd0
                     : SECTOR_W'($urandom_range(1, 16));
                pick = $urandom_range(0, 9);
                wlen = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd0
                     : CD_W'($urandom_range(1, 12));
                set_config(1'($urandom_range(0, 1)), spl, wlen);
            end
            no_gaps <= (ph == 4);
            if (burst)
                repeat (250) send_random(92, 4, 3, (ph == 2) ? 90 : 10);
            else
                repeat (90) send_random(55, 20, 18, 50);
            wait_drained();
        end
        no_gaps <= 1'b0;

        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
